>>> rtl/smx_pkg.sv
// Shared types, sizes and codes for the stack machine execute unit.
package smx_pkg;

    localparam int STACK_DEPTH   = 64;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int WORD_WIDTH    = 64;

    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
    localparam int LEN_W = 11;

    localparam logic [3:0] OP_PRINT = 4'd0;
    localparam logic [3:0] OP_PUSH  = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_EXIT  = 4'd3;
    localparam logic [3:0] OP_POP   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_EQ    = 4'd6;
    localparam logic [3:0] OP_NEQ   = 4'd7;
    localparam logic [3:0] OP_DUP   = 4'd8;
    localparam logic [3:0] OP_JMP   = 4'd9;
    localparam logic [3:0] OP_JMPZ  = 4'd10;
    localparam logic [3:0] OP_WRITE = 4'd11;
    localparam logic [3:0] OP_WCHAR = 4'd12;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_BADADDR   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_BADOP     = 3'd5;
    localparam logic [2:0] ST_HALTED    = 3'd6;

    localparam logic [1:0] EK_PRINT = 2'd0;
    localparam logic [1:0] EK_WRITE = 2'd1;
    localparam logic [1:0] EK_CHAR  = 2'd2;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [63:0] operand;
    } t_in_beat;

    typedef struct packed {
        logic [10:0]        next_pc;
        logic signed [63:0] top_value;
        logic               emit_valid;
        logic [1:0]         emit_kind;
        logic signed [63:0] emit_value;
        logic               halted;
        logic [2:0]         status;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_stat;

endpackage

>>> rtl/smx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/smx_div.sv
// Iterative signed truncating divider, one quotient bit per cycle.
module smx_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [smx_pkg::WORD_WIDTH-1:0]   i_num,
    input  logic [smx_pkg::WORD_WIDTH-1:0]   i_den,
    output logic                             o_done,
    output logic [smx_pkg::WORD_WIDTH-1:0]   o_quo
);
    import smx_pkg::*;
    localparam int W   = WORD_WIDTH;
    localparam int IW  = $clog2(W);

    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_den;
    logic [IW-1:0] r_cnt;
    logic          r_busy, r_done, r_neg;
    logic [W:0]    shifted, diff;
    logic [W-1:0]  mag_num, mag_den;

    assign mag_num = i_num[W-1] ? (~i_num + W'(1)) : i_num;
    assign mag_den = i_den[W-1] ? (~i_den + W'(1)) : i_den;

    always_comb begin
        shifted = {r_rem[W-1:0], r_quo[W-1]};
        diff    = shifted - {1'b0, r_den};
        if (!diff[W]) begin
            n_rem = diff;
            n_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_quo = {r_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= mag_num;
                r_den  <= mag_den;
                r_neg  <= i_num[W-1] ^ i_den[W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + IW'(1);
                if (r_cnt == IW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (~r_quo + W'(1)) : r_quo;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
`endif
endmodule

>>> rtl/smx_ctrl.sv
// Sequencing state machine: accept, read, optional divide, result hold.
module smx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_stall,
    input  smx_pkg::t_stat i_stat,
    output smx_pkg::t_cmd  o_cmd,
    output logic           o_in_stall,
    output logic           o_out_valid
);
    import smx_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_READ;
            S_READ: n_state = i_stat.need_div ? S_DIV : S_OUT;
            S_DIV:  if (i_stat.div_done) n_state = S_OUT;
            S_OUT:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_READ: begin
                o_cmd.div_start = i_stat.need_div;
                o_cmd.commit    = !i_stat.need_div;
            end
            S_DIV: o_cmd.commit = i_stat.div_done;
            S_OUT: o_out_valid = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

`ifndef SYNTHESIS
    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_cmd.commit) else $error("double commit");
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid) else $error("commit without result");
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> !o_out_valid) else $error("accept while result pending");
`endif
endmodule

>>> rtl/smx_dp.sv
// Datapath: machine state, stack RAM, instruction decode and result register.
module smx_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  smx_pkg::t_cmd           i_cmd,
    output smx_pkg::t_stat          o_stat,
    input  smx_pkg::t_in_beat       i_in_data,
    input  logic                    i_cfg_valid,
    input  logic [smx_pkg::LEN_W-1:0] i_cfg_data,
    output smx_pkg::t_out_beat      o_out_data
);
    import smx_pkg::*;
    localparam int W = WORD_WIDTH;

    logic [LEN_W-1:0] r_prog_len;
    logic [3:0]       r_op;
    logic [63:0]      r_arg;
    logic [CNT_W-1:0] r_cnt;
    logic [PC_W-1:0]  r_pc;
    logic [W-1:0]     r_tos;
    logic             r_stopped;
    t_out_beat        r_out;

    logic [W-1:0]     nos, quo, wv, ntos, ev;
    logic [CNT_W-1:0] cnt_m2, ncnt;
    logic [SP_W-1:0]  waddr;
    logic [PC_W-1:0]  len, npc, seq_pc;
    logic [2:0]       st;
    logic             wr, emit, halt, div_done, tgt_bad;
    logic [1:0]       kind;
    logic [31:0]      len_wide;

    assign cnt_m2 = r_cnt - CNT_W'(2);

    smx_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit && wr && st == ST_OK && !r_stopped),
        .i_waddr(waddr),
        .i_wdata(wv),
        .i_re   (i_cmd.accept),
        .i_raddr(cnt_m2[SP_W-1:0]),
        .o_rdata(nos)
    );

    smx_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (nos),
        .i_den  (r_tos),
        .o_done (div_done),
        .o_quo  (quo)
    );

    always_comb begin
        len_wide = {{(32 - LEN_W){1'b0}}, r_prog_len};
        if (r_prog_len == '0) begin
            len = PC_W'(1);
        end else if (len_wide > PROGRAM_DEPTH) begin
            len = PC_W'(PROGRAM_DEPTH);
        end else begin
            len = PC_W'(r_prog_len);
        end
    end

    assign seq_pc  = r_pc + PC_W'(1);
    assign tgt_bad = r_arg[63] || (r_arg[62:0] >= 63'(len));

    always_comb begin
        st    = ST_OK;
        npc   = seq_pc;
        ncnt  = r_cnt;
        wr    = 1'b0;
        waddr = r_cnt[SP_W-1:0];
        wv    = r_arg[W-1:0];
        ntos  = r_tos;
        emit  = 1'b0;
        kind  = EK_PRINT;
        ev    = '0;
        halt  = 1'b0;
        case (r_op)
            OP_PRINT, OP_WRITE, OP_WCHAR: begin
                if (r_cnt == '0) begin
                    st = ST_UNDERFLOW;
                end else begin
                    emit = 1'b1;
                    kind = (r_op == OP_PRINT) ? EK_PRINT :
                           (r_op == OP_WRITE) ? EK_WRITE : EK_CHAR;
                    ev   = (r_op == OP_WCHAR) ? W'(r_tos[7:0]) : r_tos;
                end
            end
            OP_PUSH, OP_DUP: begin
                if (r_op == OP_DUP && r_cnt == '0) begin
                    st = ST_UNDERFLOW;
                end else if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                    st = ST_OVERFLOW;
                end else begin
                    ncnt = r_cnt + CNT_W'(1);
                    wr   = 1'b1;
                    wv   = (r_op == OP_PUSH) ? r_arg[W-1:0] : r_tos;
                    ntos = wv;
                end
            end
            OP_ADD, OP_DIV, OP_EQ, OP_NEQ: begin
                if (r_cnt < CNT_W'(2)) begin
                    st = ST_UNDERFLOW;
                end else if (r_op == OP_DIV && r_tos == '0) begin
                    st = ST_DIVZERO;
                end else begin
                    case (r_op)
                        OP_ADD:  wv = nos + r_tos;
                        OP_DIV:  wv = quo;
                        OP_EQ:   wv = W'(nos == r_tos);
                        default: wv = W'(nos != r_tos);
                    endcase
                    ncnt  = r_cnt - CNT_W'(1);
                    wr    = 1'b1;
                    waddr = cnt_m2[SP_W-1:0];
                    ntos  = wv;
                end
            end
            OP_EXIT: begin
                if (r_cnt == '0) st = ST_UNDERFLOW;
                else halt = 1'b1;
            end
            OP_POP: begin
                if (r_cnt == '0) begin
                    st = ST_UNDERFLOW;
                end else begin
                    ncnt = r_cnt - CNT_W'(1);
                    ntos = nos;
                end
            end
            OP_JMP: begin
                if (tgt_bad) st = ST_BADADDR;
                else npc = PC_W'(r_arg[62:0]);
            end
            OP_JMPZ: begin
                if (r_cnt == '0) begin
                    st = ST_UNDERFLOW;
                end else begin
                    ncnt = r_cnt - CNT_W'(1);
                    ntos = nos;
                    if (r_tos == '0) begin
                        if (tgt_bad) st = ST_BADADDR;
                        else npc = PC_W'(r_arg[62:0]);
                    end
                end
            end
            default: st = ST_BADOP;
        endcase
        if (st == ST_OK && r_op != OP_EXIT && npc >= len) begin
            st = ST_BADADDR;
        end
        if (r_stopped) begin
            st = ST_HALTED;
        end
    end

    assign o_stat.need_div = !r_stopped && r_op == OP_DIV && r_cnt >= CNT_W'(2)
                             && r_tos != '0;
    assign o_stat.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= LEN_W'(PROGRAM_DEPTH);
            r_cnt      <= '0;
            r_pc       <= '0;
            r_stopped  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_prog_len <= i_cfg_data;
            end
            if (i_cmd.commit && !r_stopped) begin
                if (st != ST_OK) begin
                    r_stopped <= 1'b1;
                end else begin
                    r_cnt     <= ncnt;
                    r_pc      <= npc;
                    r_tos     <= ntos;
                    r_stopped <= halt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_in_data.op;
            r_arg <= i_in_data.operand;
        end
        if (i_cmd.commit) begin
            r_out.status <= st;
            if (st == ST_OK) begin
                r_out.next_pc    <= 11'(npc);
                r_out.top_value  <= (ncnt != '0) ? 64'(signed'(ntos)) : '0;
                r_out.emit_valid <= emit;
                r_out.emit_kind  <= kind;
                r_out.emit_value <= 64'(signed'(ev));
                r_out.halted     <= halt;
            end else begin
                r_out.next_pc    <= 11'(r_pc);
                r_out.top_value  <= (r_cnt != '0) ? 64'(signed'(r_tos)) : '0;
                r_out.emit_valid <= 1'b0;
                r_out.emit_kind  <= EK_PRINT;
                r_out.emit_value <= '0;
                r_out.halted     <= 1'b1;
            end
        end
    end

    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH)) else $error("stack count out of range");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped) else $error("machine restarted without reset");
    a_halted_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped && i_cmd.commit |=> $stable(r_cnt) && $stable(r_pc))
        else $error("halted machine changed state");
`endif
endmodule

>>> rtl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit.
// Usage:
//  Input channel (i_in_valid / o_in_stall, i_in_data) carries one instruction
//  per beat: opcode and signed operand. Output channel (o_out_valid /
//  i_out_stall, o_out_data) returns one result beat per instruction: next pc,
//  top of stack, emitted value, halted flag and status.
//  Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes the
//  program length; write it only while no instruction is in flight.
//  One instruction is in flight at a time. A result is formed by a read of
//  the stack RAM, then execute; a divide also passes through the iterative
//  divider. The next instruction is taken no earlier than the cycle after
//  the result beat, so no new instruction enters before the last result.
//  Reset empties the stack, clears the pc and halted flag and sets the
//  program length to 1024; stack RAM contents are not cleared.
//  While the receiver stalls, the result beat holds and no input is taken.
module stack_machine_execute_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  smx_pkg::t_in_beat         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output smx_pkg::t_out_beat        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [smx_pkg::LEN_W-1:0] i_cfg_data
);
    import smx_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    smx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid)
    );

    smx_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (i_in_data),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );
endmodule

>>> bench/stack_machine_execute_unit_tb.sv
// Testbench for the stack machine execute unit: self-checking, with random stalls.
`timescale 1ns / 1ps

module stack_machine_execute_unit_tb;
    import smx_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;

    class smx_scoreboard;
        logic [63:0]  stk [STACK_DEPTH];
        int unsigned  depth_n;
        int unsigned  pc;
        bit           stopped;
        int unsigned  prog_len;
        t_out_beat    expq [$];
        int           errors;

        function new();
            depth_n  = 0;
            pc       = 0;
            stopped  = 0;
            prog_len = PROGRAM_DEPTH;
            errors   = 0;
        endfunction

        function void set_length(logic [10:0] v);
            prog_len = (v < 1) ? 1 : (v > PROGRAM_DEPTH) ? PROGRAM_DEPTH : v;
        endfunction

        function logic [63:0] quot_trunc(logic [63:0] a, logic [63:0] d);
            logic [63:0] ma, md, q;
            ma = a[63] ? -a : a;
            md = d[63] ? -d : d;
            q  = ma / md;
            return (a[63] ^ d[63]) ? -q : q;
        endfunction

        // Execute one accepted instruction and queue the result it must produce.
        function void note_instr(t_in_beat b);
            logic [63:0] tos, nos, wv;
            int unsigned npc, ncnt;
            logic [2:0]  st;
            logic [1:0]  kind;
            logic [63:0] ev;
            bit          emit, halt, wr, jump;
            t_out_beat   e;
            tos  = depth_n > 0 ? stk[depth_n - 1] : 64'd0;
            nos  = depth_n > 1 ? stk[depth_n - 2] : 64'd0;
            npc  = pc + 1;
            ncnt = depth_n;
            st   = ST_OK;
            kind = EK_PRINT;
            ev   = '0;
            wv   = '0;
            emit = 0;
            halt = 0;
            wr   = 0;
            jump = 0;
            if (stopped) begin
                st = ST_HALTED;
            end else begin
                case (b.op)
                    OP_PRINT, OP_WRITE, OP_WCHAR: begin
                        if (depth_n < 1) begin
                            st = ST_UNDERFLOW;
                        end else begin
                            emit = 1;
                            kind = (b.op == OP_PRINT) ? EK_PRINT :
                                   (b.op == OP_WRITE) ? EK_WRITE : EK_CHAR;
                            ev   = (b.op == OP_WCHAR) ? {56'd0, tos[7:0]} : tos;
                        end
                    end
                    OP_PUSH, OP_DUP: begin
                        if (b.op == OP_DUP && depth_n < 1) st = ST_UNDERFLOW;
                        else if (depth_n >= STACK_DEPTH) st = ST_OVERFLOW;
                        else begin
                            ncnt = depth_n + 1;
                            wr   = 1;
                            wv   = (b.op == OP_PUSH) ? b.operand : tos;
                        end
                    end
                    OP_ADD, OP_DIV, OP_EQ, OP_NEQ: begin
                        if (depth_n < 2) st = ST_UNDERFLOW;
                        else if (b.op == OP_DIV && tos == 0) st = ST_DIVZERO;
                        else begin
                            case (b.op)
                                OP_ADD:  wv = nos + tos;
                                OP_DIV:  wv = quot_trunc(nos, tos);
                                OP_EQ:   wv = (nos == tos);
                                default: wv = (nos != tos);
                            endcase
                            ncnt = depth_n - 1;
                            wr   = 1;
                        end
                    end
                    OP_EXIT: begin
                        if (depth_n < 1) st = ST_UNDERFLOW;
                        else halt = 1;
                    end
                    OP_POP: begin
                        if (depth_n < 1) st = ST_UNDERFLOW;
                        else ncnt = depth_n - 1;
                    end
                    OP_JMP, OP_JMPZ: begin
                        jump = 1;
                        if (b.op == OP_JMPZ) begin
                            if (depth_n < 1) begin
                                st   = ST_UNDERFLOW;
                                jump = 0;
                            end else begin
                                ncnt = depth_n - 1;
                                jump = (tos == 0);
                            end
                        end
                        if (jump) begin
                            if (b.operand[63] || $unsigned(b.operand) >= 64'(prog_len))
                                st = ST_BADADDR;
                            else
                                npc = b.operand[10:0];
                        end
                    end
                    default: st = ST_BADOP;
                endcase
                if (st == ST_OK && b.op != OP_EXIT && npc >= prog_len) st = ST_BADADDR;
                if (st != ST_OK) begin
                    halt = 1;
                    emit = 0;
                    kind = EK_PRINT;
                    ev   = '0;
                    ncnt = depth_n;
                    wr   = 0;
                    npc  = pc;
                end
                if (wr) stk[ncnt - 1] = wv;
                depth_n = ncnt;
                pc      = npc;
                if (halt) stopped = 1;
            end
            e.next_pc    = pc[10:0];
            e.top_value  = depth_n > 0 ? stk[depth_n - 1] : 64'd0;
            e.emit_valid = emit;
            e.emit_kind  = kind;
            e.emit_value = ev;
            e.halted     = stopped;
            e.status     = st;
            expq.push_back(e);
        endfunction

        function void check_result(t_out_beat r);
            t_out_beat e;
            if (expq.size() == 0) begin
                $error("result beat with no instruction pending");
                errors++;
                return;
            end
            e = expq.pop_front();
            if (r.next_pc !== e.next_pc) begin
                $error("next_pc exp %0d got %0d", e.next_pc, r.next_pc);
                errors++;
            end
            if (r.top_value !== e.top_value) begin
                $error("top_value exp %0d got %0d", e.top_value, r.top_value);
                errors++;
            end
            if (r.emit_valid !== e.emit_valid) begin
                $error("emit_valid exp %0d got %0d", e.emit_valid, r.emit_valid);
                errors++;
            end
            if (r.emit_kind !== e.emit_kind) begin
                $error("emit_kind exp %0d got %0d", e.emit_kind, r.emit_kind);
                errors++;
            end
            if (r.emit_value !== e.emit_value) begin
                $error("emit_value exp %0d got %0d", e.emit_value, r.emit_value);
                errors++;
            end
            if (r.halted !== e.halted) begin
                $error("halted exp %0d got %0d", e.halted, r.halted);
                errors++;
            end
            if (r.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, r.status);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_in_valid = 0;
    logic                  o_in_stall;
    t_in_beat              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 0;
    t_out_beat             o_out_data;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [LEN_W-1:0]      i_cfg_data = '0;

    smx_scoreboard sb = new();
    int tx_idle = 0;
    int rx_idle = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    stack_machine_execute_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Result side: random stall, long hold-off on request, checking, watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("stack_machine_execute_unit_tb: FAIL");
                $finish;
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    task automatic send_instr(t_in_beat b);
        if ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_instr(b);
    endtask

    task automatic send_op(logic [3:0] op, logic [63:0] arg);
        t_in_beat b;
        b.op      = op;
        b.operand = arg;
        send_instr(b);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_length(v);
    endtask

    function automatic logic [63:0] rand_word();
        int v;
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: begin
                v = $urandom_range(6);
                return 64'(v - 3);
            end
            2: begin
                case ($urandom_range(3))
                    0: return 64'h7FFF_FFFF_FFFF_FFFF;
                    1: return 64'h8000_0000_0000_0000;
                    2: return 64'd0;
                    default: return '1;
                endcase
            end
            default: return 64'($urandom_range(255));
        endcase
    endfunction

    // Pick an instruction that keeps the machine running.
    function automatic t_in_beat gen_legal();
        t_in_beat    b;
        logic [63:0] tos;
        int unsigned c;
        bit          ok;
        c         = sb.depth_n;
        tos       = c > 0 ? sb.stk[c - 1] : 64'd0;
        b.operand = rand_word();
        if (sb.pc + 1 >= sb.prog_len) begin
            b.op      = (c > 0 && tos == 0) ? OP_JMPZ : OP_JMP;
            b.operand = $urandom_range(sb.prog_len - 1);
            return b;
        end
        if (c < STACK_DEPTH && $urandom_range(99) < 30) begin
            b.op = OP_PUSH;
            return b;
        end
        do begin
            b.op = 4'($urandom_range(12));
            case (b.op)
                OP_PUSH:              ok = c < STACK_DEPTH;
                OP_DUP:               ok = c >= 1 && c < STACK_DEPTH;
                OP_ADD, OP_EQ, OP_NEQ: ok = c >= 2;
                OP_DIV:               ok = c >= 2 && tos != 0;
                OP_JMP:               ok = 1;
                OP_EXIT:              ok = 0;
                default:              ok = c >= 1;
            endcase
        end while (!ok);
        if (b.op == OP_JMP || b.op == OP_JMPZ) b.operand = $urandom_range(sb.prog_len - 1);
        return b;
    endfunction

    task automatic run_legal(int n);
        repeat (n) send_instr(gen_legal());
    endtask

    // Stop the machine with one randomly chosen ending, then send noise.
    task automatic finish_machine();
        t_in_beat b;
        case ($urandom_range(7))
            0: send_op(OP_EXIT, rand_word());
            1: send_op(4'(13 + $urandom_range(2)), rand_word());
            2: begin
                send_op(OP_PUSH, 64'd0);
                send_op(OP_DIV, rand_word());
            end
            3: send_op(OP_JMP, 64'h8000_0000_0000_0000 | {$urandom, $urandom});
            4: send_op(OP_JMP, 64'(sb.prog_len) + $urandom_range(3));
            5: repeat (STACK_DEPTH + 1) send_op(OP_PUSH, rand_word());
            6: repeat (sb.depth_n + 1) send_op(OP_POP, rand_word());
            default: begin
                send_op(OP_JMP, 64'(sb.prog_len - 1));
                send_op(OP_PUSH, rand_word());
            end
        endcase
        repeat (20) begin
            b.op      = 4'($urandom_range(15));
            b.operand = rand_word();
            send_instr(b);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_op(OP_PUSH, 64'h8000_0000_0000_0000);
        send_op(OP_ADD, 64'd0);
        send_op(OP_PUSH, 64'h8000_0000_0000_0000);
        send_op(OP_PUSH, '1);
        send_op(OP_DIV, 64'd0);
        send_op(OP_PRINT, 64'd0);
        send_op(OP_WRITE, 64'd0);
        send_op(OP_WCHAR, 64'd0);
        send_op(OP_DUP, 64'd0);
        send_op(OP_EQ, 64'd0);
        send_op(OP_PUSH, 64'd0);
        send_op(OP_NEQ, 64'd0);
        send_op(OP_PUSH, 64'd0);
        send_op(OP_JMPZ, 64'd20);
        send_op(OP_JMPZ, 64'd3);
        send_op(OP_JMP, 64'd0);
        send_op(OP_POP, 64'd0);
        send_op(OP_PUSH, 64'd7);
        send_op(OP_PUSH, -64'sd2);
        send_op(OP_DIV, 64'd0);
        send_op(OP_POP, 64'd0);

        write_length(11'd2047);
        tx_idle = 24;
        rx_idle = 71;
        run_legal(200);
        hold_req = 1;
        run_legal(400);

        write_length(11'd7);
        tx_idle = 71;
        rx_idle = 24;
        run_legal(500);

        write_length(11'd0);
        tx_idle = 0;
        rx_idle = 0;
        run_legal(60);

        write_length(11'd1024);
        run_legal(200);
        drain();
        run_legal(200);

        finish_machine();
        drain();

        if (sb.errors == 0 && sb.expq.size() == 0) begin
            $display("stack_machine_execute_unit_tb: PASS");
        end else begin
            $display("stack_machine_execute_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> stack_machine_execute_unit.f
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_div.sv
rtl/smx_ctrl.sv
rtl/smx_dp.sv
rtl/stack_machine_execute_unit.sv
bench/stack_machine_execute_unit_tb.sv
